// ----- design/uhaw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package uhaw_pkg;

  // Field widths
  localparam int USAGE_W    = 10;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 42;
  localparam int LIMIT_W    = 8;
  localparam int PROD_W     = 2 * CNT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // The average never exceeds the largest sample, so the quotient has USAGE_W bits
  localparam int DIV_STEPS  = USAGE_W;

  // Reset values
  localparam logic [USAGE_W-1:0] ALARM_LEVEL_RST  = 10'd900;
  localparam logic [USAGE_W-1:0] RESUME_LEVEL_RST = 10'd800;
  localparam logic [CNT_W-1:0]   SAMPLE_MS_RST    = 32'd10000;
  localparam logic [CNT_W-1:0]   WINDOW_MS_RST    = 32'd3600000;
  localparam logic [CNT_W-1:0]   QUIET_MS_RST     = 32'd60000;
  localparam logic [LIMIT_W-1:0] REPORT_LIMIT_RST = 8'd9;
  localparam logic [USAGE_W-1:0] LEAST_RST        = 10'd1000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM_LEVEL  = 3'd0,
    REG_RESUME_LEVEL = 3'd1,
    REG_SAMPLE_MS    = 3'd2,
    REG_WINDOW_MS    = 3'd3,
    REG_QUIET_MS     = 3'd4,
    REG_REPORT_LIMIT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [USAGE_W-1:0] alarm_level;
    logic [USAGE_W-1:0] resume_level;
    logic [CNT_W-1:0]   sample_period_ms;
    logic [CNT_W-1:0]   window_period_ms;
    logic [CNT_W-1:0]   quiet_period_ms;
    logic [LIMIT_W-1:0] report_limit;
  } cfg_t;

  // Record handed from the front end to the back end
  typedef struct packed {
    logic               in_alarm;
    logic               alarm_onset;
    logic               alarm_report;
    logic               resume_event;
    logic               window_done;
    logic [USAGE_W-1:0] window_min;
    logic [USAGE_W-1:0] window_max;
    logic [SUM_W-1:0]   usage_sum;
    logic [CNT_W-1:0]   sample_count;
    logic [CNT_W-1:0]   onset_total;
    logic [CNT_W-1:0]   resume_total;
    logic [CNT_W-1:0]   alarm_time_ms;
  } rec_t;

  // Finished result
  typedef struct packed {
    logic               in_alarm;
    logic               alarm_onset;
    logic               alarm_report;
    logic               resume_event;
    logic               window_done;
    logic [USAGE_W-1:0] window_min;
    logic [USAGE_W-1:0] window_max;
    logic [USAGE_W-1:0] window_avg;
    logic [CNT_W-1:0]   onset_total;
    logic [CNT_W-1:0]   resume_total;
    logic [CNT_W-1:0]   alarm_time_ms;
  } res_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_QMUL,
    F_QCMP,
    F_WMUL,
    F_WCMP,
    F_AMUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_LOAD
  } back_state_t;

endpackage

`default_nettype wire

// ----- design/uhaw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module uhaw_front (
  input  logic                           clk,
  input  logic                           rst,
  input  uhaw_pkg::cfg_t                 cfg,
  input  logic                           push,
  output logic                           full,
  input  logic [uhaw_pkg::USAGE_W-1:0]   sample_usage,
  output logic                           rec_push,
  output uhaw_pkg::rec_t                 rec,
  input  logic                           rec_full
);
  import uhaw_pkg::*;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  front_state_t state, state_next;

  logic               alarm_flag;
  logic               quiet_active;
  logic [CNT_W-1:0]   quiet_count;
  logic [LIMIT_W-1:0] reports_given;
  logic [CNT_W-1:0]   window_samples;
  logic [SUM_W-1:0]   usage_sum;
  logic [USAGE_W-1:0] least_seen;
  logic [USAGE_W-1:0] most_seen;
  logic [CNT_W-1:0]   onset_count;
  logic [CNT_W-1:0]   resume_count;
  logic [CNT_W-1:0]   samples_in_alarm;
  logic               ev_onset;
  logic               ev_report;
  logic               ev_resume;
  logic               win_done;
  logic [PROD_W-1:0]  prod;
  logic [CNT_W-1:0]   mul_a;

  logic accept;
  logic onset_hit;
  logic resume_hit;
  logic quiet_open;
  logic report_hit;
  logic flag_after;
  logic quiet_after;
  logic prod_ge_quiet;
  logic prod_ge_window;
  logic [CNT_W-1:0] alarm_time_sat;

  // Classification of the incoming sample
  assign accept      = push && !full;
  assign onset_hit   = (sample_usage >= cfg.alarm_level) && !alarm_flag;
  assign resume_hit  = !onset_hit && (sample_usage <= cfg.resume_level) && alarm_flag;
  assign quiet_open  = onset_hit && !quiet_active;
  assign report_hit  = quiet_open && (reports_given < cfg.report_limit);
  assign flag_after  = onset_hit || (alarm_flag && !resume_hit);
  assign quiet_after = quiet_active || quiet_open;

  // Period compares at full product width
  assign prod_ge_quiet  = prod >= {{CNT_W{1'b0}}, cfg.quiet_period_ms};
  assign prod_ge_window = prod >= {{CNT_W{1'b0}}, cfg.window_period_ms};
  assign alarm_time_sat = (prod[PROD_W-1:CNT_W] != '0) ? {CNT_W{1'b1}} : prod[CNT_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = quiet_after ? F_QMUL : F_WMUL;
        end
      end
      F_QMUL: state_next = F_QCMP;
      F_QCMP: state_next = F_WMUL;
      F_WMUL: state_next = F_WCMP;
      F_WCMP: state_next = prod_ge_window ? F_AMUL : F_PUSH;
      F_AMUL: state_next = F_PUSH;
      F_PUSH: begin
        if (!rec_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Outputs: handshake, multiplier operand, record
  always_comb begin
    full     = (state != F_IDLE);
    rec_push = (state == F_PUSH) && !rec_full;
    case (state)
      F_QMUL:  mul_a = quiet_count;
      F_AMUL:  mul_a = samples_in_alarm;
      default: mul_a = window_samples;
    endcase
    rec              = '0;
    rec.in_alarm     = alarm_flag;
    rec.alarm_onset  = ev_onset;
    rec.alarm_report = ev_report;
    rec.resume_event = ev_resume;
    rec.window_done  = win_done;
    if (win_done) begin
      rec.window_min    = least_seen;
      rec.window_max    = most_seen;
      rec.usage_sum     = usage_sum;
      rec.sample_count  = window_samples;
      rec.onset_total   = onset_count;
      rec.resume_total  = resume_count;
      rec.alarm_time_ms = alarm_time_sat;
    end
  end

  // Shared 32x32 multiplier, product registered
  always_ff @(posedge clk) begin
    if (state == F_QMUL || state == F_WMUL || state == F_AMUL) begin
      prod <= PROD_W'(mul_a) * PROD_W'(cfg.sample_period_ms);
    end
  end

  // Alarm, silence and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= F_IDLE;
      alarm_flag       <= 1'b0;
      quiet_active     <= 1'b0;
      quiet_count      <= '0;
      reports_given    <= '0;
      window_samples   <= '0;
      usage_sum        <= '0;
      least_seen       <= LEAST_RST;
      most_seen        <= '0;
      onset_count      <= '0;
      resume_count     <= '0;
      samples_in_alarm <= '0;
      ev_onset         <= 1'b0;
      ev_report        <= 1'b0;
      ev_resume        <= 1'b0;
      win_done         <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (sample_usage < least_seen) least_seen <= sample_usage;
            if (sample_usage > most_seen) most_seen <= sample_usage;
            usage_sum    <= usage_sum + SUM_W'(sample_usage);
            alarm_flag   <= flag_after;
            quiet_active <= quiet_after;
            ev_onset     <= onset_hit;
            ev_report    <= report_hit;
            ev_resume    <= resume_hit;
            win_done     <= 1'b0;
            if (quiet_open) begin
              quiet_count <= CNT_W'(1);
            end else if (quiet_active) begin
              quiet_count <= sat_inc(quiet_count);
            end
            if (report_hit) reports_given <= reports_given + 1'b1;
            if (onset_hit) onset_count <= sat_inc(onset_count);
            if (resume_hit) resume_count <= sat_inc(resume_count);
            window_samples <= sat_inc(window_samples);
            if (flag_after) samples_in_alarm <= sat_inc(samples_in_alarm);
          end
        end
        F_QCMP: begin
          if (prod_ge_quiet) quiet_active <= 1'b0;
        end
        F_WCMP: begin
          win_done <= prod_ge_window;
        end
        F_PUSH: begin
          // window statistics clear once the report has been handed on
          if (!rec_full && win_done) begin
            reports_given    <= '0;
            window_samples   <= '0;
            usage_sum        <= '0;
            least_seen       <= LEAST_RST;
            most_seen        <= '0;
            onset_count      <= '0;
            resume_count     <= '0;
            samples_in_alarm <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/uhaw_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module uhaw_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  uhaw_pkg::rec_t din,
  output logic           full,
  input  logic           pop,
  output uhaw_pkg::rec_t dout,
  output logic           empty
);
  import uhaw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  rec_t                slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_BITS-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign full    = (fill == CNT_BITS'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/uhaw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module uhaw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           rec_empty,
  output logic           rec_pop,
  input  uhaw_pkg::rec_t rec,
  output logic           empty,
  input  logic           pop,
  output uhaw_pkg::res_t res
);
  import uhaw_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  back_state_t state, state_next;

  rec_t               work;
  logic [CNT_W-1:0]   rem;
  logic [USAGE_W-1:0] qsh;
  logic [STEP_W-1:0]  step;
  logic               out_valid;
  res_t               out_reg;

  logic [CNT_W:0]     trial;
  logic               trial_ge;
  logic [CNT_W:0]     trial_diff;
  logic               load_ok;
  logic               out_take;

  // One restoring-division step per cycle
  assign trial      = {rem, qsh[USAGE_W-1]};
  assign trial_ge   = trial >= {1'b0, work.sample_count};
  assign trial_diff = trial - {1'b0, work.sample_count};
  assign out_take   = pop && out_valid;
  assign load_ok    = !out_valid || pop;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!rec_empty) begin
          state_next = rec.window_done ? B_DIV : B_LOAD;
        end
      end
      B_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = B_LOAD;
      end
      B_LOAD: begin
        if (load_ok) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rec_pop = (state == B_IDLE) && !rec_empty;
    empty   = !out_valid;
    res     = out_reg;
  end

  // Work registers and divider datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!rec_empty) begin
          work <= rec;
          rem  <= rec.usage_sum[SUM_W-1:USAGE_W];
          qsh  <= rec.usage_sum[USAGE_W-1:0];
          step <= '0;
        end
      end
      B_DIV: begin
        rem  <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        qsh  <= {qsh[USAGE_W-2:0], trial_ge};
        step <= step + 1'b1;
      end
      B_LOAD: begin
        if (load_ok) begin
          out_reg.in_alarm      <= work.in_alarm;
          out_reg.alarm_onset   <= work.alarm_onset;
          out_reg.alarm_report  <= work.alarm_report;
          out_reg.resume_event  <= work.resume_event;
          out_reg.window_done   <= work.window_done;
          out_reg.window_min    <= work.window_min;
          out_reg.window_max    <= work.window_max;
          out_reg.window_avg    <= work.window_done ? qsh : '0;
          out_reg.onset_total   <= work.onset_total;
          out_reg.resume_total  <= work.resume_total;
          out_reg.alarm_time_ms <= work.alarm_time_ms;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_LOAD && load_ok) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/usage_hysteresis_alarm_with_window_stats.sv -----
// Utilization alarm with hysteresis, silence window, report limit and
// per-window statistics.
//
// Input: a sample is transferred when push is high and full is low. full is
// high while the front end works on a sample: the silence check while the
// silence window runs, the window check, the alarm time when the sample
// closes a statistics window and the hand-off to the queue, which waits
// while the queue is full. Only then is a new sample taken. These steps
// share one 32x32 multiplier for the period products.
// Output: the oldest result sits on the result ports while empty is low and
// is transferred when pop is high. A queue of QUEUE_DEPTH records separates
// the front end from the back end, which computes the window average with a
// restoring divider, one quotient bit per cycle; the back end takes one
// record at a time and divides only for a record with a window report.
// A stalled receiver holds the output register; the queue then fills and
// full stays high until pop resumes, with nothing lost.
// Configuration: cfg_ready is always high; write only while idle.
// Reset (rst, synchronous) restores register defaults, clears the alarm,
// the silence state, the window statistics and the queue.
`timescale 1ns / 1ps
`default_nettype none

module usage_hysteresis_alarm_with_window_stats #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [uhaw_pkg::USAGE_W-1:0]      sample_usage,
  output logic                              empty,
  input  logic                              pop,
  output logic                              in_alarm,
  output logic                              alarm_onset,
  output logic                              alarm_report,
  output logic                              resume_event,
  output logic                              window_done,
  output logic [uhaw_pkg::USAGE_W-1:0]      window_min,
  output logic [uhaw_pkg::USAGE_W-1:0]      window_max,
  output logic [uhaw_pkg::USAGE_W-1:0]      window_avg,
  output logic [uhaw_pkg::CNT_W-1:0]        onset_total,
  output logic [uhaw_pkg::CNT_W-1:0]        resume_total,
  output logic [uhaw_pkg::CNT_W-1:0]        alarm_time_ms,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uhaw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uhaw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import uhaw_pkg::*;

  cfg_t cfg;
  rec_t q_in;
  rec_t q_out;
  res_t res;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_level      <= ALARM_LEVEL_RST;
      cfg.resume_level     <= RESUME_LEVEL_RST;
      cfg.sample_period_ms <= SAMPLE_MS_RST;
      cfg.window_period_ms <= WINDOW_MS_RST;
      cfg.quiet_period_ms  <= QUIET_MS_RST;
      cfg.report_limit     <= REPORT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALARM_LEVEL:  cfg.alarm_level      <= cfg_data[USAGE_W-1:0];
        REG_RESUME_LEVEL: cfg.resume_level     <= cfg_data[USAGE_W-1:0];
        REG_SAMPLE_MS:    cfg.sample_period_ms <= cfg_data[CNT_W-1:0];
        REG_WINDOW_MS:    cfg.window_period_ms <= cfg_data[CNT_W-1:0];
        REG_QUIET_MS:     cfg.quiet_period_ms  <= cfg_data[CNT_W-1:0];
        REG_REPORT_LIMIT: cfg.report_limit     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  uhaw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .sample_usage (sample_usage),
    .rec_push     (q_push),
    .rec          (q_in),
    .rec_full     (q_full)
  );

  uhaw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  uhaw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_empty (q_empty),
    .rec_pop   (q_pop),
    .rec       (q_out),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  // Result ports
  assign in_alarm      = res.in_alarm;
  assign alarm_onset   = res.alarm_onset;
  assign alarm_report  = res.alarm_report;
  assign resume_event  = res.resume_event;
  assign window_done   = res.window_done;
  assign window_min    = res.window_min;
  assign window_max    = res.window_max;
  assign window_avg    = res.window_avg;
  assign onset_total   = res.onset_total;
  assign resume_total  = res.resume_total;
  assign alarm_time_ms = res.alarm_time_ms;

  // Checks
  a_stats_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !window_done) |-> (window_min == '0 && window_max == '0 &&
      window_avg == '0 && onset_total == '0 && resume_total == '0 &&
      alarm_time_ms == '0))
    else $error("statistics fields nonzero without window report");

  a_report_needs_onset: assert property (@(posedge clk) disable iff (rst)
    (!empty && alarm_report) |-> alarm_onset)
    else $error("alarm report without onset");

  a_onset_resume_excl: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(alarm_onset && resume_event))
    else $error("onset and resume in one result");

  a_flag_matches_event: assert property (@(posedge clk) disable iff (rst)
    (!empty && (alarm_onset || resume_event)) |-> (in_alarm == alarm_onset))
    else $error("alarm flag disagrees with event");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front end ready right after transfer");

endmodule

`default_nettype wire

// ----- tb/usage_alarm_monitor.sv -----
`timescale 1ns / 1ps

// Watches the sample, result and register channels of the usage alarm, keeps
// its own copy of the alarm, silence and window state, and checks every result
// against the expected one in order.
module usage_alarm_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic [uhaw_pkg::USAGE_W-1:0]    sample_usage,
  input  logic                            empty,
  input  logic                            pop,
  input  logic                            in_alarm,
  input  logic                            alarm_onset,
  input  logic                            alarm_report,
  input  logic                            resume_event,
  input  logic                            window_done,
  input  logic [uhaw_pkg::USAGE_W-1:0]    window_min,
  input  logic [uhaw_pkg::USAGE_W-1:0]    window_max,
  input  logic [uhaw_pkg::USAGE_W-1:0]    window_avg,
  input  logic [uhaw_pkg::CNT_W-1:0]      onset_total,
  input  logic [uhaw_pkg::CNT_W-1:0]      resume_total,
  input  logic [uhaw_pkg::CNT_W-1:0]      alarm_time_ms,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [uhaw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uhaw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              results_checked,
  output int                              windows_seen,
  output int                              onsets_seen,
  output int                              reports_seen
);
  import uhaw_pkg::*;

  // Register copy
  cfg_t regs;

  // Alarm and silence state, kept across windows
  logic               alarm_on;
  logic               quiet_on;
  logic [CNT_W-1:0]   quiet_ticks;

  // Window statistics
  logic [LIMIT_W-1:0] reports_sent;
  logic [CNT_W-1:0]   win_samples;
  logic [SUM_W-1:0]   usage_acc;
  logic [USAGE_W-1:0] least_usage;
  logic [USAGE_W-1:0] most_usage;
  logic [CNT_W-1:0]   onsets_win;
  logic [CNT_W-1:0]   resumes_win;
  logic [CNT_W-1:0]   alarm_samples;

  // Results still owed by the block, oldest first
  res_t owed_results[$];

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Period products are compared at full width, never wrapped
  function automatic logic period_reached(input logic [CNT_W-1:0] count,
                                          input logic [CNT_W-1:0] step_ms,
                                          input logic [CNT_W-1:0] span_ms);
    return (PROD_W'(count) * PROD_W'(step_ms)) >= PROD_W'(span_ms);
  endfunction

  function automatic void clear_window();
    reports_sent  = '0;
    win_samples   = '0;
    usage_acc     = '0;
    least_usage   = LEAST_RST;
    most_usage    = '0;
    onsets_win    = '0;
    resumes_win   = '0;
    alarm_samples = '0;
  endfunction

  // Advances the state by one sample and returns the result it should give
  function automatic res_t predict_sample(input logic [USAGE_W-1:0] u);
    res_t             r;
    logic [PROD_W-1:0] alarm_span;
    logic [SUM_W-1:0]  quot;
    r = '0;
    if (u < least_usage) least_usage = u;
    if (u > most_usage) most_usage = u;
    usage_acc = usage_acc + SUM_W'(u);

    // Hysteresis: set at or above the alarm level, clear at or below resume
    if (u >= regs.alarm_level && !alarm_on) begin
      alarm_on = 1'b1;
      r.alarm_onset = 1'b1;
      if (!quiet_on) begin
        quiet_on = 1'b1;
        quiet_ticks = '0;
        if (reports_sent < regs.report_limit) begin
          r.alarm_report = 1'b1;
          reports_sent = reports_sent + 1'b1;
        end
      end
      onsets_win = sat_inc(onsets_win);
    end else if (u <= regs.resume_level && alarm_on) begin
      alarm_on = 1'b0;
      r.resume_event = 1'b1;
      resumes_win = sat_inc(resumes_win);
    end

    win_samples = sat_inc(win_samples);
    if (alarm_on) alarm_samples = sat_inc(alarm_samples);

    // Silence window; a zero quiet period ends it in the opening step
    if (quiet_on) begin
      quiet_ticks = sat_inc(quiet_ticks);
      if (period_reached(quiet_ticks, regs.sample_period_ms, regs.quiet_period_ms))
        quiet_on = 1'b0;
    end

    r.in_alarm = alarm_on;

    // Window close: report the statistics, then start a fresh window
    if (period_reached(win_samples, regs.sample_period_ms, regs.window_period_ms)) begin
      alarm_span = PROD_W'(alarm_samples) * PROD_W'(regs.sample_period_ms);
      quot = usage_acc / SUM_W'(win_samples);
      r.window_done   = 1'b1;
      r.window_min    = least_usage;
      r.window_max    = most_usage;
      r.window_avg    = quot[USAGE_W-1:0];
      r.onset_total   = onsets_win;
      r.resume_total  = resumes_win;
      r.alarm_time_ms = (alarm_span > PROD_W'({CNT_W{1'b1}})) ? '1 : alarm_span[CNT_W-1:0];
      clear_window();
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] seen);
    if (seen !== want) begin
      mismatches++;
      $error("%s mismatch on result %0d: expected %0d, actual %0d",
             name, results_checked, want, seen);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      regs = '{ALARM_LEVEL_RST, RESUME_LEVEL_RST, SAMPLE_MS_RST, WINDOW_MS_RST,
               QUIET_MS_RST, REPORT_LIMIT_RST};
      alarm_on    = 1'b0;
      quiet_on    = 1'b0;
      quiet_ticks = '0;
      clear_window();
      owed_results.delete();
    end else begin
      // Register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALARM_LEVEL:  regs.alarm_level      = cfg_data[USAGE_W-1:0];
          REG_RESUME_LEVEL: regs.resume_level     = cfg_data[USAGE_W-1:0];
          REG_SAMPLE_MS:    regs.sample_period_ms = cfg_data[CNT_W-1:0];
          REG_WINDOW_MS:    regs.window_period_ms = cfg_data[CNT_W-1:0];
          REG_QUIET_MS:     regs.quiet_period_ms  = cfg_data[CNT_W-1:0];
          REG_REPORT_LIMIT: regs.report_limit     = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      // Result transfer, matched before this edge's sample is queued
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          $error("result transfer with no sample outstanding");
        end else begin
          want = owed_results.pop_front();
          check_field("in_alarm",      CNT_W'(want.in_alarm),     CNT_W'(in_alarm));
          check_field("alarm_onset",   CNT_W'(want.alarm_onset),  CNT_W'(alarm_onset));
          check_field("alarm_report",  CNT_W'(want.alarm_report), CNT_W'(alarm_report));
          check_field("resume_event",  CNT_W'(want.resume_event), CNT_W'(resume_event));
          check_field("window_done",   CNT_W'(want.window_done),  CNT_W'(window_done));
          check_field("window_min",    CNT_W'(want.window_min),   CNT_W'(window_min));
          check_field("window_max",    CNT_W'(want.window_max),   CNT_W'(window_max));
          check_field("window_avg",    CNT_W'(want.window_avg),   CNT_W'(window_avg));
          check_field("onset_total",   want.onset_total,   onset_total);
          check_field("resume_total",  want.resume_total,  resume_total);
          check_field("alarm_time_ms", want.alarm_time_ms, alarm_time_ms);
          results_checked++;
          if (want.window_done) windows_seen++;
          if (want.alarm_onset) onsets_seen++;
          if (want.alarm_report) reports_seen++;
        end
      end

      // Sample transfer
      if (push && !full) owed_results.push_back(predict_sample(sample_usage));
    end
    pending <= owed_results.size();
  end

endmodule

// ----- tb/usage_hysteresis_alarm_with_window_stats_test.sv -----
`timescale 1ns / 1ps

module usage_hysteresis_alarm_with_window_stats_test;
  import uhaw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;
  localparam int PHASE_SAMPLES = 172;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;

  localparam cfg_t DEFAULT_CFG = '{ALARM_LEVEL_RST, RESUME_LEVEL_RST, SAMPLE_MS_RST,
                                   WINDOW_MS_RST, QUIET_MS_RST, REPORT_LIMIT_RST};

  // Sample bands used to build runs of readings
  typedef enum int {BAND_HIGH, BAND_LOW, BAND_MID, BAND_WILD} band_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic [USAGE_W-1:0]    sample_usage = '0;
  logic                  pop = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  full, empty, cfg_ready;
  logic                  in_alarm, alarm_onset, alarm_report, resume_event, window_done;
  logic [USAGE_W-1:0]    window_min, window_max, window_avg;
  logic [CNT_W-1:0]      onset_total, resume_total, alarm_time_ms;

  int mismatches, pending, results_checked, windows_seen, onsets_seen, reports_seen;

  // Traffic shaping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_taken     = 0;
  int hold_left      = 0;

  usage_hysteresis_alarm_with_window_stats u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample_usage  (sample_usage),
    .empty         (empty),
    .pop           (pop),
    .in_alarm      (in_alarm),
    .alarm_onset   (alarm_onset),
    .alarm_report  (alarm_report),
    .resume_event  (resume_event),
    .window_done   (window_done),
    .window_min    (window_min),
    .window_max    (window_max),
    .window_avg    (window_avg),
    .onset_total   (onset_total),
    .resume_total  (resume_total),
    .alarm_time_ms (alarm_time_ms),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  usage_alarm_monitor u_monitor (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .sample_usage    (sample_usage),
    .empty           (empty),
    .pop             (pop),
    .in_alarm        (in_alarm),
    .alarm_onset     (alarm_onset),
    .alarm_report    (alarm_report),
    .resume_event    (resume_event),
    .window_done     (window_done),
    .window_min      (window_min),
    .window_max      (window_max),
    .window_avg      (window_avg),
    .onset_total     (onset_total),
    .resume_total    (resume_total),
    .alarm_time_ms   (alarm_time_ms),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .windows_seen    (windows_seen),
    .onsets_seen     (onsets_seen),
    .reports_seen    (reports_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      pop        <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Leaves valid high so back-to-back writes need no lowering in between
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_ALARM_LEVEL,  CFG_DATA_W'(c.alarm_level));
    write_reg(REG_RESUME_LEVEL, CFG_DATA_W'(c.resume_level));
    write_reg(REG_SAMPLE_MS,    c.sample_period_ms);
    write_reg(REG_WINDOW_MS,    c.window_period_ms);
    write_reg(REG_QUIET_MS,     c.quiet_period_ms);
    write_reg(REG_REPORT_LIMIT, CFG_DATA_W'(c.report_limit));
  endtask

  task automatic send_sample(input logic [USAGE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    sample_usage <= v;
    do @(posedge clk); while (full);
  endtask

  // Stop offering samples and wait until every owed result has been taken
  task automatic finish_burst();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic cfg_t make_cfg(input bit extreme);
    cfg_t c;
    if (extreme) begin
      // Huge periods: windows of one to four samples, alarm time that may saturate
      c.alarm_level      = $urandom_range(1) ? 10'd1000 : 10'd0;
      c.resume_level     = (c.alarm_level == 0) ? 10'd1000 : 10'd0;
      c.sample_period_ms = $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
      c.window_period_ms = '1;
      c.quiet_period_ms  = '1;
      c.report_limit     = '1;
    end else begin
      c.alarm_level      = USAGE_W'($urandom_range(1000, 100));
      c.resume_level     = USAGE_W'(($urandom_range(9) == 0) ? $urandom_range(1000, 0)
                                    : $urandom_range(c.alarm_level, 0));
      c.sample_period_ms = $urandom_range(2000, 1);
      c.window_period_ms = c.sample_period_ms * $urandom_range(30, 2)
                         + $urandom_range(c.sample_period_ms - 1, 0);
      c.quiet_period_ms  = c.sample_period_ms * $urandom_range(5, 0)
                         + ($urandom_range(1) ? 0 : $urandom_range(c.sample_period_ms - 1, 0));
      c.report_limit     = LIMIT_W'($urandom_range(5, 0));
    end
    return c;
  endfunction

  // One configuration, then runs of samples crossing the alarm levels
  task automatic run_phase(input cfg_t c, input int idle_pct, input int stall_pct,
                           input int pause_at, input int hold_at);
    band_t              band;
    int                 run_left;
    int                 pick;
    logic [USAGE_W-1:0] v;
    program_regs(c);
    cfg_valid      <= 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    band           = BAND_MID;
    run_left       = 0;
    for (int i = 0; i < PHASE_SAMPLES; i++) begin
      if (i == pause_at) finish_burst();
      if (i == hold_at) hold_asked++;
      if (run_left == 0) begin
        pick     = $urandom_range(99);
        band     = (pick < 42) ? BAND_HIGH : (pick < 84) ? BAND_LOW :
                   (pick < 95) ? BAND_MID : BAND_WILD;
        run_left = $urandom_range(6, 1);
      end
      run_left--;
      case (band)
        BAND_HIGH: v = USAGE_W'($urandom_range(1000, c.alarm_level));
        BAND_LOW:  v = USAGE_W'($urandom_range(c.resume_level, 0));
        BAND_MID:  v = USAGE_W'($urandom_range(1000, 0));
        default:   v = USAGE_W'($urandom_range(1023, $urandom_range(1) ? 1001 : 0));
      endcase
      send_sample(v);
    end
    finish_burst();
  endtask

  initial begin
    cfg_t c;
    int   waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset levels: onset at 900, resume at 800, then an out-of-range reading
    send_sample(10'd900);
    send_sample(10'd800);
    send_sample(10'd1023);
    finish_burst();

    // Six-sample windows, no silence, one report per window; the alarm level
    // is also written with junk in its upper bits, and the spare indexes too
    c = '{alarm_level: 10'd500, resume_level: 10'd300, sample_period_ms: 32'd1,
          window_period_ms: 32'd6, quiet_period_ms: 32'd0, report_limit: 8'd1};
    program_regs(c);
    write_reg(REG_ALARM_LEVEL, {22'h3F_FFFF, c.alarm_level});
    write_reg(SPARE_IDX_LO, '1);
    write_reg(SPARE_IDX_HI, '0);
    cfg_valid <= 1'b0;
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd300);
    send_sample(10'd500);
    send_sample(10'd301);
    send_sample(10'd300);
    finish_burst();

    // Extreme levels and periods: alarm time saturates after two samples
    c = '{alarm_level: 10'd1000, resume_level: 10'd0, sample_period_ms: 32'h8000_0000,
          window_period_ms: 32'hFFFF_FFFF, quiet_period_ms: 32'hFFFF_FFFF,
          report_limit: 8'hFF};
    program_regs(c);
    cfg_valid <= 1'b0;
    send_sample(10'd1000);
    send_sample(10'd1000);
    send_sample(10'd0);
    send_sample(10'd1023);
    finish_burst();

    // Zero sample and window periods: every sample closes a window
    c = '{alarm_level: 10'd0, resume_level: 10'd1000, sample_period_ms: 32'd0,
          window_period_ms: 32'd0, quiet_period_ms: 32'd0, report_limit: 8'd3};
    program_regs(c);
    cfg_valid <= 1'b0;
    send_sample(10'd5);
    send_sample(10'd1023);
    send_sample(10'd0);
    finish_burst();

    // Zero sample period with nonzero spans: window and silence never end
    c = '{alarm_level: 10'd600, resume_level: 10'd200, sample_period_ms: 32'd0,
          window_period_ms: 32'd1, quiet_period_ms: 32'd5, report_limit: 8'd9};
    program_regs(c);
    cfg_valid <= 1'b0;
    send_sample(10'd1000);
    send_sample(10'd0);
    send_sample(10'd1000);
    send_sample(10'd0);
    finish_burst();

    // Random phases over the traffic patterns
    run_phase(DEFAULT_CFG, 0, 0, -1, -1);
    run_phase(make_cfg(1'b0), 65, 0, 90, -1);
    run_phase(make_cfg(1'b0), 0, 65, -1, 40);
    run_phase(make_cfg(1'b0), 20, 20, -1, -1);
    run_phase(make_cfg(1'b1), 0, 0, -1, -1);
    c = make_cfg(1'b0);
    c.report_limit = '0;
    run_phase(c, 65, 0, -1, -1);
    run_phase(make_cfg(1'b1), 0, 65, -1, 60);
    run_phase(make_cfg(1'b0), 20, 20, -1, -1);

    // Drain, then give a stray result time to show up
    push   <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);

    $display("Checked %0d samples across %0d statistics windows", results_checked,
             windows_seen);
    $display("Saw %0d alarm onsets and %0d alarm reports", onsets_seen, reports_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
